### rtl/sine_tone_generator_core_defines.svh
// Assertion macros for the sine tone generator core.
// Each macro expects a clock named i_clk and a synchronous active-low reset i_rst_n.
`ifndef SINE_TONE_GENERATOR_CORE_DEFINES_SVH
`define SINE_TONE_GENERATOR_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define STG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define STG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stg_pkg.sv
// Shared types, codes and constants of the sine tone generator core.
// No dependencies; imported by sine_tone_generator_core.
package stg_pkg;

    localparam int STG_PHASE_BITS   = 32;
    localparam int STG_MAX_CHANNELS = 8;
    localparam int STG_CFG_IDX_W    = 3;
    localparam int STG_CFG_DATA_W   = 32;

    // Channel count limit: the smaller of the channel maximum and eight results.
    localparam logic [3:0] STG_RESULT_LIMIT =
        (STG_MAX_CHANNELS < 8) ? 4'(STG_MAX_CHANNELS) : 4'd8;

    // Operation codes of an input word.
    localparam logic OP_RENDER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Configuration register indexes.
    localparam logic [STG_CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd0;
    localparam logic [STG_CFG_IDX_W-1:0] CFG_PHASE_OFFSET  = 3'd1;
    localparam logic [STG_CFG_IDX_W-1:0] CFG_AMPLITUDE     = 3'd2;
    localparam logic [STG_CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 3'd3;
    localparam logic [STG_CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

    // Sample format codes; any other code is treated as int32.
    localparam logic [1:0] FMT_INT8  = 2'd0;
    localparam logic [1:0] FMT_INT16 = 2'd1;

    localparam logic [31:0] SCALE_INT8  = 32'd127;
    localparam logic [31:0] SCALE_INT16 = 32'h0000_7FFF;
    localparam logic [31:0] SCALE_INT32 = 32'h7FFF_FFFF;

    // Multiplication steps of one render word.
    localparam logic [3:0] STEP_SQUARE = 4'd0;
    localparam logic [3:0] STEP_SINE   = 4'd7;
    localparam logic [3:0] STEP_AMP    = 4'd8;
    localparam logic [3:0] STEP_SCALE  = 4'd9;

    localparam logic [3:0] COEF_TOP = 4'd6;

    typedef struct packed {
        logic        operation;
        logic [31:0] new_time;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [2:0]         channel_index;
        logic               last_in_frame;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_OFFSET,
        ST_FOLD,
        ST_LOAD,
        ST_MUL,
        ST_POST,
        ST_EMIT
    } t_state;

    // Odd sine polynomial in a quarter-turn Q30 angle, Q30 coefficients.
    function automatic logic signed [31:0] sin_coef(input logic [2:0] k);
        logic signed [31:0] c;
        case (k)
            3'd0:    c = 32'sd1686629713;
            3'd1:    c = -32'sd693598668;
            3'd2:    c = 32'sd85569306;
            3'd3:    c = -32'sd5026995;
            3'd4:    c = 32'sd172272;
            3'd5:    c = -32'sd3864;
            3'd6:    c = 32'sd61;
            default: c = 32'sd0;
        endcase
        return c;
    endfunction

endpackage

### rtl/sine_tone_generator_core.sv
// Sine tone generator core: phase accumulation, polynomial sine, scaling, channel fan-out.
// Depends on stg_pkg and sine_tone_generator_core_defines.svh.
// A render word runs one bit-serial phase multiply and then ten shared bit-serial
// multiplies before its first output word. Output words then follow one per cycle
// while i_out_stall is low. A load word only sets the sample time and starts no multiply.
// Synchronous active-low reset: idle, sample time 0, registers at their defaults.
`include "sine_tone_generator_core_defines.svh"

module sine_tone_generator_core
    import stg_pkg::*;
#(
    parameter int PHASE_BITS = STG_PHASE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [STG_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [STG_CFG_DATA_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_word                  i_in_word,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_word                 o_out_word
);

    localparam logic signed [32:0] QUARTER   = 33'sh0_4000_0000;
    localparam logic signed [32:0] HALF      = 33'sh0_8000_0000;
    localparam logic signed [32:0] NEG_HALF  = 33'sh1_8000_0000;
    localparam logic [34:0]        Q30_ONE   = 35'h0_4000_0000;
    localparam logic [4:0]         LAST_BIT  = 5'd31;

    t_state r_state, n_state;

    logic [31:0]            r_phase_step;
    logic [31:0]            r_phase_offset;
    logic [15:0]            r_amplitude;
    logic [1:0]             r_sample_format;
    logic [3:0]             r_channel_count;
    logic [31:0]            r_sample_time;

    logic [PHASE_BITS-1:0]  r_phase;
    logic [31:0]            r_time_sh;
    logic signed [32:0]     r_ang;
    logic [30:0]            r_w;
    logic signed [35:0]     r_acc;
    logic [31:0]            r_mul_a;
    logic [31:0]            r_mul_b;
    logic [63:0]            r_prod;
    logic                   r_neg;
    logic [4:0]             r_cnt;
    logic [3:0]             r_step;
    logic signed [31:0]     r_value;
    logic [2:0]             r_chan;

    logic                   in_accept;
    logic [PHASE_BITS+31:0] step_w;
    logic [PHASE_BITS+31:0] offset_w;
    logic [PHASE_BITS+31:0] phase_ext;
    logic [31:0]            angle;
    logic signed [32:0]     ang_raw;
    logic signed [32:0]     ang_fold;
    logic [32:0]            ang_abs;
    logic [35:0]            acc_abs;
    logic [31:0]            y_mag;
    logic                   y_neg;
    logic [31:0]            fmt_scale;
    logic [32:0]            mul_sum;
    logic [35:0]            mag36;
    logic signed [35:0]     res30;
    logic signed [35:0]     coef_ext;
    logic [2:0]             coef_idx;
    logic [34:0]            amp_mag;
    logic [30:0]            amp_clamp;
    logic signed [35:0]     amp_res;
    logic [32:0]            round_t;
    logic [31:0]            scale_mag;
    logic [3:0]             chan_n;
    logic                   chan_last;

    assign in_accept = i_in_valid && !o_in_stall;

    // Phase registers follow PHASE_BITS: extend or truncate the 32-bit registers.
    assign step_w    = {{PHASE_BITS{1'b0}}, r_phase_step};
    assign offset_w  = {{PHASE_BITS{1'b0}}, r_phase_offset};
    assign phase_ext = {r_phase, 32'b0};
    assign angle     = phase_ext[PHASE_BITS+31 -: 32];

    // Fold the angle into a quarter turn around zero, using sin(1/2 - x) = sin(x).
    assign ang_raw = {angle[31], angle};
    always_comb begin
        if (ang_raw > QUARTER) begin
            ang_fold = HALF - ang_raw;
        end else if (ang_raw < -QUARTER) begin
            ang_fold = NEG_HALF - ang_raw;
        end else begin
            ang_fold = ang_raw;
        end
    end

    assign ang_abs = r_ang[32] ? 33'(-r_ang) : 33'(r_ang);
    assign acc_abs = r_acc[35] ? 36'(-r_acc) : 36'(r_acc);

    always_comb begin
        case (r_sample_format)
            FMT_INT8:  fmt_scale = SCALE_INT8;
            FMT_INT16: fmt_scale = SCALE_INT16;
            default:   fmt_scale = SCALE_INT32;
        endcase
    end

    // Second operand of the shared multiplier; the first is always the accumulator.
    always_comb begin
        y_neg = 1'b0;
        case (r_step)
            STEP_SQUARE, STEP_SINE: begin
                y_mag = ang_abs[31:0];
                y_neg = r_ang[32];
            end
            STEP_AMP:   y_mag = 32'(r_amplitude);
            STEP_SCALE: y_mag = fmt_scale;
            default:    y_mag = 32'(r_w);
        endcase
    end

    assign mul_sum = {1'b0, r_prod[63:32]} + (r_mul_b[0] ? {1'b0, r_mul_a} : 33'd0);

    // Post-processing of a finished product, truncated toward zero.
    assign mag36    = {2'b00, r_prod[63:30]};
    assign res30    = r_neg ? -$signed(mag36) : $signed(mag36);
    assign coef_idx = 3'(COEF_TOP - r_step);
    assign coef_ext = 36'(sin_coef(coef_idx));

    assign amp_mag   = r_prod[46:12];
    assign amp_clamp = (amp_mag > Q30_ONE) ? Q30_ONE[30:0] : amp_mag[30:0];
    assign amp_res   = r_neg ? -$signed({5'b0, amp_clamp}) : $signed({5'b0, amp_clamp});

    // Round half away from zero: ((p >> 29) + 1) >> 1 on the magnitude.
    assign round_t   = {1'b0, r_prod[60:29]} + 33'd1;
    assign scale_mag = round_t[32:1];

    assign chan_n    = (r_channel_count > STG_RESULT_LIMIT) ? STG_RESULT_LIMIT
                                                            : r_channel_count;
    assign chan_last = (r_chan == 3'(chan_n - 4'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_EMIT);
        o_out_word  = '{sample_value: r_value, channel_index: r_chan,
                        last_in_frame: chan_last};
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_word.operation == OP_RENDER) begin
                    n_state = ST_PHASE;
                end
            end
            ST_PHASE: begin
                if (r_cnt == LAST_BIT) begin
                    n_state = ST_OFFSET;
                end
            end
            ST_OFFSET: n_state = ST_FOLD;
            ST_FOLD:   n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_MUL;
            ST_MUL: begin
                if (r_cnt == LAST_BIT) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                if (r_step != STEP_SCALE) begin
                    n_state = ST_LOAD;
                end else if (chan_n == 4'd0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_out_stall && chan_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step    <= '0;
            r_phase_offset  <= '0;
            r_amplitude     <= 16'd4096;
            r_sample_format <= FMT_INT16;
            r_channel_count <= 4'd1;
            r_sample_time   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PHASE_STEP:    r_phase_step    <= i_cfg_data;
                    CFG_PHASE_OFFSET:  r_phase_offset  <= i_cfg_data;
                    CFG_AMPLITUDE:     r_amplitude     <= i_cfg_data[15:0];
                    CFG_SAMPLE_FORMAT: r_sample_format <= i_cfg_data[1:0];
                    CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                if (i_in_word.operation == OP_LOAD) begin
                    r_sample_time <= i_in_word.new_time;
                end else begin
                    r_sample_time <= r_sample_time + 32'd1;
                end
            end
        end
    end

    // Datapath: payload registers, sequenced by r_state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_phase   <= '0;
                r_time_sh <= r_sample_time;
                r_cnt     <= '0;
            end
            ST_PHASE: begin
                // One multiplier bit of the sample time per cycle, MSB first.
                r_phase   <= (r_phase << 1)
                           + (r_time_sh[31] ? step_w[PHASE_BITS-1:0] : '0);
                r_time_sh <= r_time_sh << 1;
                r_cnt     <= r_cnt + 5'd1;
            end
            ST_OFFSET: begin
                r_phase <= r_phase + offset_w[PHASE_BITS-1:0];
            end
            ST_FOLD: begin
                r_ang  <= ang_fold;
                r_acc  <= 36'(ang_fold);
                r_step <= STEP_SQUARE;
            end
            ST_LOAD: begin
                r_mul_a <= acc_abs[31:0];
                r_mul_b <= y_mag;
                r_neg   <= r_acc[35] ^ y_neg;
                r_prod  <= '0;
                r_cnt   <= '0;
            end
            ST_MUL: begin
                // Shift-add, multiplier LSB first; the high half collects the sum.
                r_prod  <= {mul_sum, r_prod[31:1]};
                r_mul_b <= r_mul_b >> 1;
                r_cnt   <= r_cnt + 5'd1;
            end
            ST_POST: begin
                case (r_step)
                    STEP_SQUARE: begin
                        r_w   <= r_prod[60:30];
                        r_acc <= 36'(sin_coef(COEF_TOP[2:0]));
                    end
                    STEP_SINE:  r_acc <= res30;
                    STEP_AMP:   r_acc <= amp_res;
                    STEP_SCALE: r_value <= r_neg ? -$signed(scale_mag) : $signed(scale_mag);
                    default:    r_acc <= coef_ext + res30;
                endcase
                r_step <= r_step + 4'd1;
                r_chan <= '0;
            end
            ST_EMIT: begin
                if (!i_out_stall) begin
                    r_chan <= r_chan + 3'd1;
                end
            end
            default: ;
        endcase
    end

    `STG_ASSERT_NOW(a_out_holds_input, o_out_valid, o_in_stall, "input taken while words pending")
    `STG_ASSERT_NEXT(a_render_starts, in_accept && i_in_word.operation == OP_RENDER, r_state == ST_PHASE, "render word did not start the phase multiply")
    `STG_ASSERT_NEXT(a_load_silent, in_accept && i_in_word.operation == OP_LOAD, !o_out_valid && r_sample_time == $past(i_in_word.new_time), "load word misbehaved")
    `STG_ASSERT_NOW(a_chan_range, o_out_valid, 4'(r_chan) < chan_n, "channel index beyond channel count")
    `STG_ASSERT_NOW(a_step_range, r_state == ST_MUL, r_step <= STEP_SCALE, "multiply step out of range")

endmodule

### tb/sine_tone_generator_core_test.sv
// Self-checking testbench for sine_tone_generator_core: directed table, then random words.
// Depends on stg_pkg; predicts every output word with its own fixed-point sine model.
module sine_tone_generator_core_test
    import stg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESET_CYCLES      = 11;
    localparam int          DRAIN_CYCLES      = 400;
    localparam int          FRAME_RESULTS_MAX = 8;
    localparam int          WORDS_PER_SEGMENT = 36;
    localparam int          PRINT_LIMIT       = 100;
    localparam longint      Q30_ONE           = 64'sd1073741824;
    localparam logic [1:0]  FMT_INT32         = 2'd2;
    localparam logic [1:0]  FMT_SPARE         = 2'd3;
    localparam bit          ROW_WORD          = 1'b0;
    localparam bit          ROW_CFG           = 1'b1;
    localparam bit          PREDICTED         = 1'b0;
    localparam bit          TYPED             = 1'b1;
    localparam t_in_word    NO_WORD           = '{OP_RENDER, 32'd0};

    // Odd Taylor-like sine polynomial in a quarter-turn Q30 angle.
    localparam longint SINE_POLY [7] = '{
        64'sd1686629713, -64'sd693598668, 64'sd85569306, -64'sd5026995,
        64'sd172272, -64'sd3864, 64'sd61
    };

    typedef struct packed {
        bit                        is_cfg;
        logic [STG_CFG_IDX_W-1:0]  idx;
        logic [31:0]               data;
        t_in_word                  word;
        bit                        typed;
        logic signed [31:0]        want;
    } t_row;

    // Directed part: register writes and words, expected sample typed where obvious.
    t_row plan [0:42] = '{
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'hA5A5_5A5A}, TYPED, 32'sd0},
        '{ROW_CFG, CFG_PHASE_OFFSET, 32'h4000_0000, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'h5A5A_A5A5}, TYPED, 32'sd32767},
        '{ROW_CFG, CFG_SAMPLE_FORMAT, {30'd0, FMT_INT8}, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'hFFFF_FFFF}, TYPED, 32'sd127},
        '{ROW_CFG, CFG_SAMPLE_FORMAT, {30'd0, FMT_INT32}, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, TYPED, 32'sd2147483647},
        '{ROW_CFG, CFG_SAMPLE_FORMAT, {30'd0, FMT_SPARE}, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_PHASE_OFFSET, 32'hC000_0000, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'h1234_5678}, TYPED, -32'sd2147483647},
        '{ROW_CFG, CFG_AMPLITUDE, 32'd0, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, TYPED, 32'sd0},
        '{ROW_CFG, CFG_AMPLITUDE, 32'h0000_FFFF, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_SAMPLE_FORMAT, {30'd0, FMT_INT16}, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_CHANNEL_COUNT, 32'd8, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, TYPED, -32'sd32767},
        '{ROW_CFG, CFG_CHANNEL_COUNT, 32'd15, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, TYPED, -32'sd32767},
        '{ROW_CFG, CFG_CHANNEL_COUNT, 32'd0, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_PHASE_OFFSET, 32'h8000_0000, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_CHANNEL_COUNT, 32'd3, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, TYPED, 32'sd0},
        '{ROW_CFG, CFG_AMPLITUDE, 32'h0000_1000, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_PHASE_STEP, 32'hFFFF_FFFF, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_PHASE_OFFSET, 32'd0, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_LOAD, 32'hFFFF_FFFF}, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_PHASE_STEP, 32'h0123_4567, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_PHASE_OFFSET, 32'h9ABC_DEF0, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_LOAD, 32'h8000_0000}, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_AMPLITUDE, 32'h0000_0800, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_CHANNEL_COUNT, 32'd2, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_AMPLITUDE, 32'h0000_1800, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_CFG, CFG_SAMPLE_FORMAT, {30'd0, FMT_INT8}, NO_WORD, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_LOAD, 32'h7FFF_FFFF}, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, PREDICTED, 32'sd0},
        '{ROW_WORD, '0, 32'd0, '{OP_RENDER, 32'd0}, PREDICTED, 32'sd0}
    };

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [STG_CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [STG_CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    t_in_word                  i_in_word   = NO_WORD;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_out_word                 o_out_word;

    // Predictor copy of the registers and the sample-time counter.
    logic [31:0] tone_step;
    logic [31:0] tone_offset;
    logic [15:0] tone_amplitude;
    logic [1:0]  tone_format;
    logic [3:0]  tone_channels;
    logic [31:0] tone_time;

    t_out_word   pending_samples [$];
    int          mismatch_count   = 0;
    int          in_idle_pct      = 0;
    int          out_stall_pct    = 0;
    bit          words_since_idle = 1'b0;

    sine_tone_generator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endtask

    // (a*b) >> sh on magnitudes, so the quotient truncates toward zero.
    function automatic longint mul_trunc(input longint a, input longint b, input int sh);
        bit                neg;
        longint unsigned   ma;
        longint unsigned   mb;
        longint unsigned   p;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = (ma * mb) >> sh;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint poly_sine_q30(input logic [31:0] angle);
        longint a;
        longint w;
        longint acc;
        a = $signed(angle);
        // Fold into a quarter turn either side of zero: sin(half turn - x) = sin(x).
        if (a > Q30_ONE) begin
            a = 2 * Q30_ONE - a;
        end else if (a < -Q30_ONE) begin
            a = -2 * Q30_ONE - a;
        end
        w   = mul_trunc(a, a, 30);
        acc = SINE_POLY[6];
        for (int k = 5; k >= 0; k--) begin
            acc = SINE_POLY[k] + mul_trunc(acc, w, 30);
        end
        return mul_trunc(acc, a, 30);
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            CFG_PHASE_STEP:    tone_step      = data;
            CFG_PHASE_OFFSET:  tone_offset    = data;
            CFG_AMPLITUDE:     tone_amplitude = data[15:0];
            CFG_SAMPLE_FORMAT: tone_format    = data[1:0];
            CFG_CHANNEL_COUNT: tone_channels  = data[3:0];
            default: ;
        endcase
    endfunction

    // Works out the channel words one input word causes and queues them.
    function automatic void predict_tone_word(input t_in_word w);
        logic [31:0]     angle;
        longint          s;
        longint unsigned scale;
        longint unsigned mag;
        logic [31:0]     v;
        int              n;
        t_out_word       o;
        if (w.operation == OP_LOAD) begin
            tone_time = w.new_time;
            return;
        end
        angle = tone_time * tone_step + tone_offset;
        s = mul_trunc(poly_sine_q30(angle), longint'(tone_amplitude), 12);
        if (s > Q30_ONE) s = Q30_ONE;
        if (s < -Q30_ONE) s = -Q30_ONE;
        case (tone_format)
            FMT_INT8:  scale = 127;
            FMT_INT16: scale = 64'h7FFF;
            default:   scale = 64'h7FFF_FFFF;
        endcase
        mag = (s < 0) ? -s : s;
        mag = (mag * scale + (64'd1 << 29)) >> 30;
        v   = (s < 0) ? -mag[31:0] : mag[31:0];
        n   = tone_channels;
        if (n > STG_MAX_CHANNELS) n = STG_MAX_CHANNELS;
        if (n > FRAME_RESULTS_MAX) n = FRAME_RESULTS_MAX;
        for (int c = 0; c < n; c++) begin
            o.sample_value  = v;
            o.channel_index = c[2:0];
            o.last_in_frame = (c + 1 == n);
            pending_samples.push_back(o);
        end
        tone_time = tone_time + 32'd1;
    endfunction

    // Drops valid, waits until every expected word has come, then lets the block settle.
    task automatic settle_idle(input int extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
        words_since_idle = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Returns in the time step of the edge that accepted the word.
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_since_idle = 1'b1;
    endtask

    task automatic random_settings();
        logic [31:0] junk;
        junk = $urandom;
        case ($urandom_range(5))
            0:       write_reg(CFG_PHASE_STEP, 32'd0);
            1:       write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
            2, 3:    write_reg(CFG_PHASE_STEP, $urandom);
            default: write_reg(CFG_PHASE_STEP, $urandom_range(32'h0100_0000));
        endcase
        write_reg(CFG_PHASE_OFFSET, ($urandom_range(3) == 0) ? 32'd0 : $urandom);
        // Bits above each narrow register are random; the block must ignore them.
        case ($urandom_range(5))
            0:       write_reg(CFG_AMPLITUDE, {junk[31:16], 16'h0000});
            1:       write_reg(CFG_AMPLITUDE, {junk[31:16], 16'h1000});
            2:       write_reg(CFG_AMPLITUDE, {junk[31:16], 16'hFFFF});
            3:       write_reg(CFG_AMPLITUDE, {junk[31:16], 16'($urandom)});
            default: write_reg(CFG_AMPLITUDE, {junk[31:16], 16'($urandom_range(16'h1400))});
        endcase
        write_reg(CFG_SAMPLE_FORMAT, {junk[31:2], 2'($urandom_range(3))});
        if ($urandom_range(7) == 0) begin
            write_reg(CFG_CHANNEL_COUNT, {junk[31:4], 4'($urandom_range(15))});
        end else begin
            write_reg(CFG_CHANNEL_COUNT, {junk[31:4], 4'($urandom_range(8, 1))});
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected output word %h", o_out_word));
            end else begin
                want = pending_samples.pop_front();
                if (o_out_word.sample_value !== want.sample_value) begin
                    report_mismatch($sformatf("sample_value got %0d want %0d",
                        o_out_word.sample_value, want.sample_value));
                end
                if (o_out_word.channel_index !== want.channel_index) begin
                    report_mismatch($sformatf("channel_index got %0d want %0d",
                        o_out_word.channel_index, want.channel_index));
                end
                if (o_out_word.last_in_frame !== want.last_in_frame) begin
                    report_mismatch($sformatf("last_in_frame got %0b want %0b",
                        o_out_word.last_in_frame, want.last_in_frame));
                end
            end
        end
    end

    initial begin
        int       first;
        t_in_word w;
        tone_step      = 32'd0;
        tone_offset    = 32'd0;
        tone_amplitude = 16'h1000;
        tone_format    = FMT_INT16;
        tone_channels  = 4'd1;
        tone_time      = 32'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                if (words_since_idle) settle_idle(DRAIN_CYCLES);
                write_reg(plan[r].idx, plan[r].data);
            end else begin
                send_word(plan[r].word);
                first = pending_samples.size();
                predict_tone_word(plan[r].word);
                if (plan[r].typed) begin
                    for (int i = first; i < pending_samples.size(); i++) begin
                        pending_samples[i].sample_value = plan[r].want;
                    end
                end
            end
        end

        // Random part: four idling mixes, two register settings under each.
        for (int p = 0; p < 4; p++) begin
            for (int s = 0; s < 2; s++) begin
                settle_idle(DRAIN_CYCLES);
                in_idle_pct   = (p == 1) ? 85 : (p == 3) ? 30 : 0;
                out_stall_pct = (p == 2) ? 85 : (p == 3) ? 30 : 0;
                random_settings();
                for (int k = 0; k < WORDS_PER_SEGMENT; k++) begin
                    if ($urandom_range(29) == 0) settle_idle(0);
                    w.new_time  = $urandom;
                    w.operation = OP_RENDER;
                    if ($urandom_range(99) < 15) begin
                        w.operation = OP_LOAD;
                        if ($urandom_range(3) == 0) begin
                            w.new_time = 32'hFFFF_FFFF - $urandom_range(3);
                        end
                    end
                    send_word(w);
                    predict_tone_word(w);
                end
            end
        end

        settle_idle(DRAIN_CYCLES);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/stg_pkg.sv
rtl/sine_tone_generator_core.sv
tb/sine_tone_generator_core_test.sv
